[src/assert_macros.svh]
// Assertion helpers for the RTL, included by the calibrate-percent unit.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge, skipped while reset is active.
`define AECP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("aecp assertion failed");

// Check a property on every rising edge, reset included.
`define AECP_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("aecp assertion failed");

`else

`define AECP_ASSERT(label, clk, rst_n, prop)
`define AECP_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

[src/aecp_pkg.sv]
`timescale 1ns / 1ps

package aecp_pkg;

    // Field and register widths
    localparam int LEVEL_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 3;
    localparam int ALPHA_W   = 17;
    localparam int LIMIT_W   = 21;
    localparam int FACTOR_W  = 32;

    // Shared multiplier and wide datapath widths
    localparam int MUL_W   = 32;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIDE_W  = 96;
    localparam int LIN_W   = 48;
    localparam int SQT_W   = 52;
    localparam int ADJ_W   = 54;

    // Unity smoothing weight, Q1.16
    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

    // Magnitude cap of the square term
    localparam logic [WIDE_W-1:0] SQ_CAP = 96'(1) << 50;

    // Saturation bounds of the calibrated value
    localparam logic signed [ADJ_W-1:0] ADJ_LEV_MAX = 54'sd2147483647;
    localparam logic signed [ADJ_W-1:0] ADJ_LEV_MIN = -54'sd2147483648;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EMA_ALPHA  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_LINEAR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_SQUARE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 3'd5;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE,
        S_EMA0,
        S_EMA1,
        S_EMA2,
        S_LIN,
        S_SQ,
        S_SQL,
        S_SQH,
        S_SQC,
        S_SQR,
        S_ADJ,
        S_RANGE,
        S_NUM,
        S_SCALE,
        S_DINIT,
        S_DIV,
        S_PCT,
        S_FIN
    } aecp_state_t;

endpackage

[src/aecp_if.sv]
`timescale 1ns / 1ps

// Sample channel: one converter reading per transaction
interface aecp_sample_if
    import aecp_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] raw_sample;
    logic                   restart;

    modport source (output valid, output raw_sample, output restart, input ready);
    modport sink   (input valid, input raw_sample, input restart, output ready);
endinterface

// Level channel: one result per transaction
interface aecp_level_if
    import aecp_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [LEVEL_W-1:0] level;
    logic                      is_percent;
    logic                      range_error;

    modport source (output valid, output level, output is_percent, output range_error,
                    input ready);
    modport sink   (input valid, input level, input is_percent, input range_error,
                    output ready);
endinterface

[src/adc_ema_calibrate_percent_unit.sv]
// Channel   Dir  Handshake        Payload
// samples   in   valid / ready    raw_sample[SAMPLE_BITS], restart
// levels    out  valid / ready    level[32] signed, is_percent, range_error
// cfg       in   cfg_we           cfg_index[3], cfg_data[32]
//
// One sample runs through the shared 32x32 multiplier passes and, when scaling is on,
// the one-bit-per-cycle percent divider. samples.ready is high only while the
// sequencer is idle.
// A finished level waits in the output register; a stalled output holds the
// next result in the final state until the register frees.
// Reset is asynchronous, active low; no clearing pass is needed.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module adc_ema_calibrate_percent_unit
    import aecp_pkg::*;
#(
    parameter int SAMPLE_BITS   = 12,
    parameter int FRACTION_BITS = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    aecp_sample_if.sink          samples,
    aecp_level_if.source         levels
);

    localparam int FB     = SAMPLE_BITS + FRACTION_BITS;
    localparam int ACC_W  = FB + 17;
    localparam int SQ_SH  = FRACTION_BITS + 24;
    localparam int QW     = FRACTION_BITS + 7;
    localparam int CNT_W  = $clog2(QW);
    localparam int SCL_W  = LIMIT_W + FRACTION_BITS;
    localparam int D_W    = LIMIT_W + FRACTION_BITS;
    localparam int NUM_W  = QW + LIMIT_W;
    localparam logic [LEVEL_W-1:0] PCT_FULL = 32'(100) << FRACTION_BITS;

    // Configuration registers
    logic [ALPHA_W-1:0]         alpha_reg;
    logic signed [LIMIT_W-1:0]  offset_reg;
    logic signed [FACTOR_W-1:0] linf_reg;
    logic signed [FACTOR_W-1:0] sqf_reg;
    logic signed [LIMIT_W-1:0]  low_reg;
    logic signed [LIMIT_W-1:0]  high_reg;

    // Sequencer and filter state
    aecp_state_t             state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [FB-1:0]           filt_reg, filt_next;
    logic                    empty_reg, empty_next;
    logic [FB-1:0]           samp_reg, samp_next;

    // Datapath registers
    logic [PROD_W-1:0]        prod_reg;
    logic [ACC_W-1:0]         acc_reg, acc_next;
    logic signed [LIN_W-1:0]  lterm_reg, lterm_next;
    logic [PROD_W-1:0]        sq_reg, sq_next;
    logic [PROD_W-1:0]        pl_reg, pl_next;
    logic [WIDE_W-1:0]        sum_reg, sum_next;
    logic signed [SQT_W-1:0]  sqt_reg, sqt_next;
    logic signed [ADJ_W-1:0]  adj_reg, adj_next;
    logic                     inv_reg, inv_next;
    logic [LIMIT_W-1:0]       den_reg, den_next;
    logic signed [SCL_W-1:0]  lo_reg, lo_next;
    logic signed [SCL_W-1:0]  clamp_reg, clamp_next;
    logic [D_W-1:0]           d_reg, d_next;
    logic [NUM_W-1:0]         num_reg, num_next;
    logic [LIMIT_W-1:0]       rem_reg, rem_next;
    logic [QW-1:0]            quo_reg, quo_next;
    logic [LEVEL_W-1:0]       wlev_reg, wlev_next;
    logic                     wpct_reg, wpct_next;
    logic                     werr_reg, werr_next;

    // Output register
    logic                     ovalid_reg, ovalid_next;
    logic [LEVEL_W-1:0]       olev_reg, olev_next;
    logic                     opct_reg, opct_next;
    logic                     oerr_reg, oerr_next;

    // Shared multiplier operands
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [MUL_W-1:0]         lin_mag, sq_mag;

    logic                     in_fire;

    assign in_fire = samples.valid && samples.ready;
    assign lin_mag = linf_reg[FACTOR_W-1] ? MUL_W'(-linf_reg) : MUL_W'(linf_reg);
    assign sq_mag  = sqf_reg[FACTOR_W-1] ? MUL_W'(-sqf_reg) : MUL_W'(sqf_reg);

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg  <= ALPHA_ONE;
            offset_reg <= '0;
            linf_reg   <= 32'sd65536;
            sqf_reg    <= '0;
            low_reg    <= '0;
            high_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EMA_ALPHA:
                begin
                    if (cfg_data[16] && (|cfg_data[15:0]))
                        alpha_reg <= ALPHA_ONE;
                    else
                        alpha_reg <= cfg_data[ALPHA_W-1:0];
                end
                REG_CAL_OFFSET: offset_reg <= $signed(cfg_data[LIMIT_W-1:0]);
                REG_CAL_LINEAR: linf_reg   <= $signed(cfg_data[FACTOR_W-1:0]);
                REG_CAL_SQUARE: sqf_reg    <= $signed(cfg_data[FACTOR_W-1:0]);
                REG_RANGE_LOW:  low_reg    <= $signed(cfg_data[LIMIT_W-1:0]);
                REG_RANGE_HIGH: high_reg   <= $signed(cfg_data[LIMIT_W-1:0]);
                default: ;
            endcase
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cnt_reg    <= '0;
            filt_reg   <= '0;
            empty_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            filt_reg   <= filt_next;
            empty_reg  <= empty_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Advance datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg  <= mul_a * mul_b;
        samp_reg  <= samp_next;
        acc_reg   <= acc_next;
        lterm_reg <= lterm_next;
        sq_reg    <= sq_next;
        pl_reg    <= pl_next;
        sum_reg   <= sum_next;
        sqt_reg   <= sqt_next;
        adj_reg   <= adj_next;
        inv_reg   <= inv_next;
        den_reg   <= den_next;
        lo_reg    <= lo_next;
        clamp_reg <= clamp_next;
        d_reg     <= d_next;
        num_reg   <= num_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        wlev_reg  <= wlev_next;
        wpct_reg  <= wpct_next;
        werr_reg  <= werr_next;
        olev_reg  <= olev_next;
        opct_reg  <= opct_next;
        oerr_reg  <= oerr_next;
    end

    // Sequence one sample through the shared multiplier and divider
    always_comb
    begin
        logic [FB-1:0]           s_in;
        logic [ACC_W-1:0]        ema_sum;
        logic [PROD_W-1:0]       lin_round;
        logic signed [LIN_W-1:0] lin_abs;
        logic [WIDE_W-1:0]       sq_round;
        logic [WIDE_W-1:0]       sq_res;
        logic signed [SQT_W-1:0] sq_abs;
        logic signed [LIMIT_W-1:0] mn, mx;
        logic signed [LIMIT_W:0] span;
        logic signed [SCL_W-1:0] lo_s, hi_s;
        logic [LIMIT_W:0]        trial;
        logic [LEVEL_W-1:0]      pct;

        state_next  = state_reg;
        cnt_next    = cnt_reg;
        filt_next   = filt_reg;
        empty_next  = empty_reg;
        samp_next   = samp_reg;
        acc_next    = acc_reg;
        lterm_next  = lterm_reg;
        sq_next     = sq_reg;
        pl_next     = pl_reg;
        sum_next    = sum_reg;
        sqt_next    = sqt_reg;
        adj_next    = adj_reg;
        inv_next    = inv_reg;
        den_next    = den_reg;
        lo_next     = lo_reg;
        clamp_next  = clamp_reg;
        d_next      = d_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        wlev_next   = wlev_reg;
        wpct_next   = wpct_reg;
        werr_next   = werr_reg;
        ovalid_next = ovalid_reg;
        olev_next   = olev_reg;
        opct_next   = opct_reg;
        oerr_next   = oerr_reg;
        mul_a       = '0;
        mul_b       = '0;

        s_in      = FB'(samples.raw_sample) << FRACTION_BITS;
        ema_sum   = acc_reg + ACC_W'(prod_reg);
        lin_round = prod_reg + (PROD_W'(1) << 15);
        lin_abs   = $signed(LIN_W'(lin_round >> 16));
        sq_round  = sum_reg + (WIDE_W'(1) << (SQ_SH - 1));
        sq_res    = sq_round >> SQ_SH;
        if (sq_res > SQ_CAP)
            sq_res = SQ_CAP;
        sq_abs    = $signed(SQT_W'(sq_res));
        mn        = (low_reg > high_reg) ? high_reg : low_reg;
        mx        = (low_reg > high_reg) ? low_reg : high_reg;
        span      = (LIMIT_W + 1)'(mx) - (LIMIT_W + 1)'(mn);
        lo_s      = SCL_W'(mn) <<< FRACTION_BITS;
        hi_s      = SCL_W'(mx) <<< FRACTION_BITS;
        trial     = {rem_reg, num_reg[QW-1]};
        pct       = (LEVEL_W'(quo_reg) > PCT_FULL) ? PCT_FULL : LEVEL_W'(quo_reg);

        // Drain the output register
        if (ovalid_reg && levels.ready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (samples.valid)
                begin
                    samp_next  = s_in;
                    empty_next = 1'b0;
                    if (samples.restart || empty_reg || alpha_reg[ALPHA_W-1])
                    begin
                        filt_next  = s_in;
                        state_next = S_LIN;
                    end
                    else
                        state_next = S_EMA0;
                end
            end
            S_EMA0:
            begin
                mul_a      = MUL_W'(filt_reg);
                mul_b      = MUL_W'(ALPHA_ONE - alpha_reg);
                state_next = S_EMA1;
            end
            S_EMA1:
            begin
                mul_a      = MUL_W'(samp_reg);
                mul_b      = MUL_W'(alpha_reg);
                acc_next   = ACC_W'(prod_reg) + (ACC_W'(1) << 15);
                state_next = S_EMA2;
            end
            S_EMA2:
            begin
                filt_next  = FB'(ema_sum >> 16);
                state_next = S_LIN;
            end
            S_LIN:
            begin
                mul_a      = MUL_W'(filt_reg);
                mul_b      = lin_mag;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                mul_a      = MUL_W'(filt_reg);
                mul_b      = MUL_W'(filt_reg);
                lterm_next = linf_reg[FACTOR_W-1] ? -lin_abs : lin_abs;
                state_next = S_SQL;
            end
            S_SQL:
            begin
                sq_next    = prod_reg;
                mul_a      = prod_reg[MUL_W-1:0];
                mul_b      = sq_mag;
                state_next = S_SQH;
            end
            S_SQH:
            begin
                pl_next    = prod_reg;
                mul_a      = sq_reg[PROD_W-1:MUL_W];
                mul_b      = sq_mag;
                state_next = S_SQC;
            end
            S_SQC:
            begin
                sum_next   = {prod_reg, {MUL_W{1'b0}}} + WIDE_W'(pl_reg);
                state_next = S_SQR;
            end
            S_SQR:
            begin
                sqt_next   = sqf_reg[FACTOR_W-1] ? -sq_abs : sq_abs;
                state_next = S_ADJ;
            end
            S_ADJ:
            begin
                adj_next   = (ADJ_W'(offset_reg) <<< FRACTION_BITS)
                           + ADJ_W'(lterm_reg) + ADJ_W'(sqt_reg);
                state_next = S_RANGE;
            end
            S_RANGE:
            begin
                inv_next = low_reg > high_reg;
                den_next = span[LIMIT_W-1:0];
                lo_next  = lo_s;
                if (adj_reg < ADJ_W'(lo_s))
                    clamp_next = lo_s;
                else if (adj_reg > ADJ_W'(hi_s))
                    clamp_next = hi_s;
                else
                    clamp_next = SCL_W'(adj_reg);

                // Pass the calibrated value when scaling is off
                if (low_reg == '0 && high_reg == '0)
                begin
                    wpct_next = 1'b0;
                    werr_next = 1'b0;
                    if (adj_reg > ADJ_LEV_MAX)
                        wlev_next = LEVEL_W'(ADJ_LEV_MAX);
                    else if (adj_reg < ADJ_LEV_MIN)
                        wlev_next = LEVEL_W'(ADJ_LEV_MIN);
                    else
                        wlev_next = LEVEL_W'(adj_reg);
                    state_next = S_FIN;
                end
                else if (mn == mx)
                begin
                    wpct_next  = 1'b1;
                    werr_next  = 1'b1;
                    wlev_next  = '0;
                    state_next = S_FIN;
                end
                else
                begin
                    wpct_next  = 1'b1;
                    werr_next  = 1'b0;
                    state_next = S_NUM;
                end
            end
            S_NUM:
            begin
                d_next     = D_W'(clamp_reg - lo_reg);
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                // Times 100 as 64 + 32 + 4, plus half the divisor for rounding
                num_next   = (NUM_W'(d_reg) << 6) + (NUM_W'(d_reg) << 5)
                           + (NUM_W'(d_reg) << 2) + NUM_W'(den_reg >> 1);
                state_next = S_DINIT;
            end
            S_DINIT:
            begin
                rem_next   = LIMIT_W'(num_reg >> QW);
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Restoring division, one quotient bit per cycle
                num_next = num_reg << 1;
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = LIMIT_W'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[QW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[LIMIT_W-1:0];
                    quo_next = {quo_reg[QW-2:0], 1'b0};
                end
                if (cnt_reg == CNT_W'(QW - 1))
                    state_next = S_PCT;
                else
                    cnt_next = cnt_reg + 1'b1;
            end
            S_PCT:
            begin
                wlev_next  = inv_reg ? (PCT_FULL - pct) : pct;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                // Load the output register once it is free
                if (!ovalid_reg || levels.ready)
                begin
                    ovalid_next = 1'b1;
                    olev_next   = wlev_reg;
                    opct_next   = wpct_reg;
                    oerr_next   = werr_reg;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Drive channel ports
    assign samples.ready      = (state_reg == S_IDLE);
    assign levels.valid       = ovalid_reg;
    assign levels.level       = $signed(olev_reg);
    assign levels.is_percent  = opct_reg;
    assign levels.range_error = oerr_reg;

    // Checks
    `AECP_ASSERT(a_busy_after_accept, clk, rst_n, in_fire |=> !samples.ready)
    `AECP_ASSERT(a_err_forces_zero, clk, rst_n, (levels.valid && levels.range_error) |-> (levels.is_percent && levels.level == '0))
    `AECP_ASSERT(a_pct_in_range, clk, rst_n, (levels.valid && levels.is_percent) |-> (!levels.level[LEVEL_W-1] && LEVEL_W'(levels.level) <= PCT_FULL))
    `AECP_ASSERT(a_div_count, clk, rst_n, (state_reg == S_DIV) |-> (cnt_reg <= CNT_W'(QW - 1)))
    `AECP_ASSERT(a_empty_clears_on_accept, clk, rst_n, $fell(empty_reg) |-> $past(in_fire))

endmodule
